// ===== sv/per_flow_packet_rate_limiter_assert.svh =====
// assertion macros for the per-flow rate limiter checks
// clk and rst_n must be visible where the macros are used
`ifndef PER_FLOW_PACKET_RATE_LIMITER_ASSERT_SVH
`define PER_FLOW_PACKET_RATE_LIMITER_ASSERT_SVH

// same-cycle implication, off during reset
`define PFRL_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pfrl: same-cycle check failed");

// next-cycle implication, off during reset
`define PFRL_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pfrl: next-cycle check failed");

`endif

// ===== sv/pfrl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pfrl_pkg;

  // table geometry
  localparam int FLOW_ENTRIES = 256;
  localparam int IDX_W        = $clog2(FLOW_ENTRIES);

  // field widths
  localparam int FLOW_W   = 8;
  localparam int TIME_W   = 48;
  localparam int COUNT_W  = 24;
  localparam int PERIOD_W = 22;
  localparam int LIMIT_W  = 16;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 22;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(3000);
  localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = LIMIT_W'(20);

  // rate arithmetic
  localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;
  localparam logic [TIME_W-1:0]  IDLE_LIMIT_MS = TIME_W'(3600 * 1000);
  localparam int MS_PER_SECOND = 1000;
  // count * 1000 always fits in this many bits
  localparam int LHS_W = 34;
  localparam int RHS_W = LIMIT_W + LHS_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD_MS  = 1'b0,
    REG_RATE_LIMIT = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    OP_PACKET = 1'b0,
    OP_SWEEP  = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t             opcode;
    logic [FLOW_W-1:0]   flow_index;
    logic [TIME_W-1:0]   now_ms;
    logic                whitelisted;
  } in_item_t;

  typedef struct packed {
    logic packet_dropped;
    logic spared_by_whitelist;
    logic entry_removed;
  } out_item_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] period_ms;
    logic [LIMIT_W-1:0]  rate_limit;
  } cfg_t;

  // one table entry as stored in the memory
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [TIME_W-1:0]  win_start;
  } entry_t;

  // table write request from the update logic
  typedef struct packed {
    logic             valid_we;
    logic             valid_val;
    logic             mem_we;
    logic [IDX_W-1:0] idx;
    entry_t           entry;
  } tbl_wr_t;

endpackage

`default_nettype wire

// ===== sv/pfrl_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pfrl_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pfrl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pfrl_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output pfrl_pkg::cfg_t                   cfg
);

  pfrl_pkg::cfg_t cfg_r;

  // writes are always accepted and land in the register at the accepting edge
  assign cfg_ready = 1'b1;
  assign cfg      = cfg_r;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.period_ms  <= pfrl_pkg::PERIOD_RESET;
      cfg_r.rate_limit <= pfrl_pkg::LIMIT_RESET;
    end else if (cfg_valid) begin
      case (pfrl_pkg::cfg_reg_t'(cfg_index))
        pfrl_pkg::REG_PERIOD_MS: begin
          cfg_r.period_ms <= cfg_wdata[pfrl_pkg::PERIOD_W-1:0];
        end
        pfrl_pkg::REG_RATE_LIMIT: begin
          cfg_r.rate_limit <= cfg_wdata[pfrl_pkg::LIMIT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/pfrl_flow_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pfrl_flow_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [pfrl_pkg::IDX_W-1:0]    rd_idx,
  input  pfrl_pkg::tbl_wr_t             wr,
  output pfrl_pkg::entry_t              rd_entry,
  output logic                          rd_valid
);

  pfrl_pkg::entry_t                       mem [pfrl_pkg::FLOW_ENTRIES];
  pfrl_pkg::entry_t                       rd_q_r;
  logic [pfrl_pkg::IDX_W-1:0]             rd_idx_r;
  logic [pfrl_pkg::FLOW_ENTRIES-1:0]      vld_r;
  logic                                   byp_vld_r;
  logic [pfrl_pkg::IDX_W-1:0]             byp_idx_r;
  pfrl_pkg::entry_t                       byp_entry_r;

  // entry memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr.mem_we) begin
      mem[wr.idx] <= wr.entry;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_idx];
    end
  end

  // valid bits and bypass flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      byp_vld_r <= 1'b0;
    end else begin
      if (wr.valid_we) begin
        vld_r[wr.idx] <= wr.valid_val;
      end
      if (wr.mem_we) begin
        byp_vld_r <= 1'b1;
      end
    end
  end

  // read address and last written entry
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_idx_r <= rd_idx;
    end
    if (wr.mem_we) begin
      byp_idx_r   <= wr.idx;
      byp_entry_r <= wr.entry;
    end
  end

  // a write at the read edge is missed by the memory, take it from the bypass
  assign rd_entry = (byp_vld_r && (byp_idx_r == rd_idx_r)) ? byp_entry_r : rd_q_r;
  assign rd_valid = vld_r[rd_idx_r];

endmodule

`default_nettype wire

// ===== sv/pfrl_update.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pfrl_update (
  input  pfrl_pkg::in_item_t   item,
  input  logic                 fire,
  input  logic                 entry_valid,
  input  pfrl_pkg::entry_t     entry,
  input  pfrl_pkg::cfg_t       cfg,
  output pfrl_pkg::out_item_t  res,
  output pfrl_pkg::tbl_wr_t    wr
);

  logic                            in_range;
  logic                            is_pkt;
  logic [pfrl_pkg::COUNT_W-1:0]    cnt_base;
  logic [pfrl_pkg::COUNT_W-1:0]    cnt_inc;
  logic [pfrl_pkg::TIME_W-1:0]     ws_base;
  logic                            backwards;
  logic [pfrl_pkg::TIME_W-1:0]     elapsed;
  logic                            closed;
  logic                            el_hi;
  logic [pfrl_pkg::LHS_W-1:0]      lhs;
  logic [pfrl_pkg::RHS_W-1:0]      rhs;
  logic                            over;
  logic                            idle;
  logic                            restart;

  assign in_range = int'(item.flow_index) < pfrl_pkg::FLOW_ENTRIES;
  assign is_pkt   = (item.opcode == pfrl_pkg::OP_PACKET);

  // a free entry starts empty with its window at now
  assign cnt_base = entry_valid ? entry.count : '0;
  assign ws_base  = entry_valid ? entry.win_start : item.now_ms;
  assign cnt_inc  = (cnt_base == pfrl_pkg::COUNT_MAX) ? cnt_base
                                                      : cnt_base + pfrl_pkg::COUNT_W'(1);

  // window age, shared by the packet and the sweep paths
  assign backwards = item.now_ms < ws_base;
  assign elapsed   = item.now_ms - ws_base;
  assign closed    = !backwards &&
                     (elapsed >= pfrl_pkg::TIME_W'(cfg.period_ms));

  // count * 1000 >= limit * elapsed; a nonzero limit over a huge window never trips
  assign el_hi = |elapsed[pfrl_pkg::TIME_W-1:pfrl_pkg::LHS_W];
  assign lhs   = pfrl_pkg::LHS_W'(cnt_inc) * pfrl_pkg::LHS_W'(pfrl_pkg::MS_PER_SECOND);
  assign rhs   = pfrl_pkg::RHS_W'(cfg.rate_limit) *
                 pfrl_pkg::RHS_W'(elapsed[pfrl_pkg::LHS_W-1:0]);
  assign over  = closed && (el_hi ? (cfg.rate_limit == '0)
                                  : (pfrl_pkg::RHS_W'(lhs) >= rhs));

  // the over flag is consumed by the packet that raises it, so it is never stored
  assign idle    = entry_valid && !backwards && (elapsed >= pfrl_pkg::IDLE_LIMIT_MS);
  assign restart = backwards || closed;

  // result
  assign res.packet_dropped      = in_range && is_pkt && over && !item.whitelisted;
  assign res.spared_by_whitelist = in_range && is_pkt && over && item.whitelisted;
  assign res.entry_removed       = in_range && !is_pkt && idle;

  // table write-back
  assign wr.idx             = pfrl_pkg::IDX_W'(item.flow_index);
  assign wr.mem_we          = fire && in_range && is_pkt;
  assign wr.valid_we        = fire && in_range && (is_pkt || idle);
  assign wr.valid_val       = is_pkt;
  assign wr.entry.count     = restart ? '0 : cnt_inc;
  assign wr.entry.win_start = restart ? item.now_ms : ws_base;

endmodule

`default_nettype wire

// ===== sv/per_flow_packet_rate_limiter.sv =====
// Per-flow packet rate limiter. Each request carries an opcode, a flow index,
// the time in ms and a whitelist flag; a packet request updates that flow's
// count and window and answers whether the packet is dropped or spared, a
// sweep request frees the flow if it has been idle for an hour. One request
// can be taken every cycle while the result side keeps up; its result is
// offered from the result register after it passes the request stage: the
// taking edge reads the flow table (a 256 x 72 single-port-write memory with
// registered read), and the edge that moves the request stage on does the
// read-modify-write and loads the result register. A stalled result holds the
// request stage and with it the input. Back-to-back requests to the same flow
// are handled by a one-entry write bypass. Valid bits of all entries clear in
// the reset cycle; no clearing pass is needed. Configuration writes are always
// accepted and must be made while no request is in flight.
`timescale 1ns / 1ps
`default_nettype none

module per_flow_packet_rate_limiter (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  pfrl_pkg::in_item_t               in_item,
  output logic                             out_valid,
  input  logic                             out_ready,
  output pfrl_pkg::out_item_t              out_item,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pfrl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pfrl_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  pfrl_pkg::cfg_t       cfg;
  logic                 s1_vld_r;
  pfrl_pkg::in_item_t   s1_item_r;
  logic                 out_vld_r;
  pfrl_pkg::out_item_t  out_item_r;
  logic                 s1_adv;
  logic                 in_acc;
  pfrl_pkg::entry_t     rd_entry;
  logic                 rd_valid;
  pfrl_pkg::out_item_t  res;
  pfrl_pkg::tbl_wr_t    wr;

  pfrl_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // handshake: the compute stage moves when the result register is free
  assign s1_adv   = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !s1_vld_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  pfrl_flow_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_acc),
    .rd_idx   (pfrl_pkg::IDX_W'(in_item.flow_index)),
    .wr       (wr),
    .rd_entry (rd_entry),
    .rd_valid (rd_valid)
  );

  pfrl_update u_update (
    .item        (s1_item_r),
    .fire        (s1_adv),
    .entry_valid (rd_valid),
    .entry       (rd_entry),
    .cfg         (cfg),
    .res         (res),
    .wr          (wr)
  );

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_vld_r <= in_valid;
      end
      if (s1_adv) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_item;
    end
    if (s1_adv) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// ===== sv/pfrl_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "per_flow_packet_rate_limiter_assert.svh"

module pfrl_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  pfrl_pkg::out_item_t  out_item
);

  // a stalled result holds
  `PFRL_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item))

  // at most one outcome per result
  `PFRL_ASSERT_IMP(a_out_onehot, out_valid, $onehot0(out_item))

  // requests are only held off by a stalled result
  `PFRL_ASSERT_IMP(a_in_backpressure, !in_ready, out_valid && !out_ready)

  // a fresh result comes from a request taken into the request stage and then moved to the result register
  `PFRL_ASSERT_IMP(a_out_latency, $rose(out_valid), $past(in_valid && in_ready, 2))

endmodule

bind per_flow_packet_rate_limiter pfrl_checker u_pfrl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

`default_nettype wire
